// ===== rtl/core/substring_match_position_scorer_defines.svh =====
// ----------------------------------------------------------------------------
// substring_match_position_scorer_defines
// assertion macros shared by the scorer modules
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_POSITION_SCORER_DEFINES_SVH
`define SUBSTRING_MATCH_POSITION_SCORER_DEFINES_SVH

// invariant checked on every clock edge out of reset
`define SMPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SMPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/smps_pkg.sv =====
// ----------------------------------------------------------------------------
// smps_pkg
// types, constants and reset values of the substring match position scorer
// ----------------------------------------------------------------------------
package smps_pkg;

  localparam int PAT_MAX    = 64;
  localparam int LANE_W     = $clog2(PAT_MAX);
  localparam int LEN_W      = $clog2(PAT_MAX + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DELIM_SLOTS = 3;

  localparam logic [LEN_W-1:0]   LEN_FULL  = LEN_W'(PAT_MAX);
  localparam logic [FIFO_AW:0]   FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);
  localparam logic [FIFO_AW-1:0] FIFO_LAST = FIFO_AW'(FIFO_DEPTH - 1);
  localparam logic [15:0]        POS_MAX   = 16'hFFFF;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WEIGHT  = 3'd0,
    CFG_MAX_WEIGHT  = 3'd1,
    CFG_USE_DELIM   = 3'd2,
    CFG_DELIM_CHARS = 3'd3,
    CFG_DELIM_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MS_RUN,
    MS_PASS
  } match_state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] score;
    logic        found;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_weight;
    logic [15:0] max_weight;
    logic        use_delimiter;
    logic [23:0] delimiter_chars;
    logic [1:0]  delimiter_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_weight:      16'd0,
    max_weight:      16'd1000,
    use_delimiter:   1'b1,
    delimiter_chars: 24'h2B5F2D,
    delimiter_count: 2'd3
  };

  // classified item between front and match engine
  typedef struct packed {
    op_t        op;
    logic [7:0] chr;
    logic       last;
  } work_item_t;

  // match engine result for the scoring stage
  typedef struct packed {
    logic        clr;
    logic        text;
    logic        last;
    logic        hit;
    logic [15:0] start;
    logic [7:0]  prev_chr;
  } hit_info_t;

endpackage

// ===== rtl/core/smps_front.sv =====
// ----------------------------------------------------------------------------
// smps_front
// input register: accepts items, decodes the operation and folds case
// ----------------------------------------------------------------------------
module smps_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  smps_pkg::in_item_t     in_data,
  output logic                   wr_valid,
  input  logic                   wr_ready,
  output smps_pkg::work_item_t   wr_item
);

  logic                 hold_valid_r;
  smps_pkg::work_item_t hold_r;
  logic [7:0]           folded;

  always_comb begin
    folded = in_data.char_code;
    if (in_data.char_code >= smps_pkg::ASCII_UPPER_A &&
        in_data.char_code <= smps_pkg::ASCII_UPPER_Z) begin
      folded = in_data.char_code + smps_pkg::ASCII_CASE_GAP;
    end
  end

  assign in_ready = !hold_valid_r || wr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r.op   <= smps_pkg::op_t'(in_data.operation);
      hold_r.chr  <= folded;
      hold_r.last <= in_data.last;
    end
  end

  assign wr_valid = hold_valid_r;
  assign wr_item  = hold_r;

endmodule

// ===== rtl/core/smps_fifo.sv =====
// ----------------------------------------------------------------------------
// smps_fifo
// short queue between the front register and the match engine
// ----------------------------------------------------------------------------
`include "substring_match_position_scorer_defines.svh"

module smps_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  smps_pkg::work_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output smps_pkg::work_item_t pop_item
);

  smps_pkg::work_item_t             mem_r [smps_pkg::FIFO_DEPTH];
  logic [smps_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [smps_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [smps_pkg::FIFO_AW:0]       count_r;
  logic                             push;
  logic                             pop;

  assign push_ready = count_r != smps_pkg::FIFO_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == smps_pkg::FIFO_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == smps_pkg::FIFO_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SMPS_ASSERT_ALWAYS(a_fifo_bound, count_r <= smps_pkg::FIFO_FULL, "fifo count overflow")
  `SMPS_ASSERT_IMPL(a_fifo_empty_ptrs, count_r == '0, wr_ptr_r == rd_ptr_r, "empty fifo pointers differ")

endmodule

// ===== rtl/core/smps_match.sv =====
// ----------------------------------------------------------------------------
// smps_match
// pattern store, per-lane prefix match vector, 1 text byte/cycle if no stall
// ----------------------------------------------------------------------------
`include "substring_match_position_scorer_defines.svh"

module smps_match (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  smps_pkg::work_item_t q_item,
  output logic                 hit_valid,
  input  logic                 hit_ready,
  output smps_pkg::hit_info_t  hit_info
);

  logic [7:0]                    pat_r  [smps_pkg::PAT_MAX];
  logic [7:0]                    hist_r [smps_pkg::PAT_MAX];
  logic [smps_pkg::PAT_MAX-1:0]  lane_r;
  logic [smps_pkg::PAT_MAX-1:0]  lane_nxt;
  logic [smps_pkg::PAT_MAX-1:0]  m_new;
  logic [smps_pkg::PAT_MAX:0]    lane_ext;
  logic [smps_pkg::LEN_W-1:0]    len_r;
  logic                          done_r;
  logic [15:0]                   pos_r;
  smps_pkg::match_state_t        state_r;
  smps_pkg::match_state_t        state_nxt;
  logic [smps_pkg::LANE_W-1:0]   k_r;
  logic [smps_pkg::LANE_W-1:0]   j_r;
  logic                          ok_r;
  logic                          hit_valid_r;
  smps_pkg::hit_info_t           hit_r;

  logic                          slot_free;
  logic                          pop;
  logic                          is_text;
  logic                          clr;
  logic                          fits;
  logic                          pass_go;
  logic                          pass_eq;
  logic                          pass_end;
  logic                          hit_raw;
  logic [smps_pkg::LEN_W-1:0]    len_eff;
  logic [smps_pkg::LEN_W-1:0]    len_dec;
  logic [smps_pkg::LANE_W-1:0]   len_m1;
  logic [15:0]                   start;

  assign slot_free = !hit_valid_r || hit_ready;
  assign pop       = q_valid && slot_free && (state_r == smps_pkg::MS_RUN);
  assign is_text   = q_item.op == smps_pkg::OP_TEXT;
  assign clr       = !is_text && done_r;
  assign len_eff   = clr ? '0 : len_r;
  assign fits      = len_eff < smps_pkg::LEN_FULL;
  // appended byte after text has streamed: rebuild its lane from history
  assign pass_go   = pop && !is_text && !clr && fits && (pos_r > 16'(len_r));
  assign len_dec   = len_r - 1'b1;
  assign len_m1    = len_dec[smps_pkg::LANE_W-1:0];
  assign pass_eq   = hist_r[k_r] == pat_r[j_r - k_r];
  assign pass_end  = k_r == j_r;

  assign lane_ext = {lane_r, 1'b1};

  always_comb begin
    for (int i = 0; i < smps_pkg::PAT_MAX; i++) begin
      m_new[i] = lane_ext[i] && (pat_r[i] == q_item.chr) && (i < int'(len_r));
    end
  end

  assign hit_raw = (len_r != '0) && m_new[len_m1];
  assign start   = (pos_r == smps_pkg::POS_MAX) ? smps_pkg::POS_MAX : pos_r - 16'(len_m1);

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    case (state_r)
      smps_pkg::MS_RUN: begin
        q_ready = slot_free;
        if (pass_go) begin
          state_nxt = smps_pkg::MS_PASS;
        end
      end
      smps_pkg::MS_PASS: begin
        if (pass_end) begin
          state_nxt = smps_pkg::MS_RUN;
        end
      end
      default: state_nxt = smps_pkg::MS_RUN;
    endcase
  end

  always_comb begin
    lane_nxt = lane_r;
    if (pop && is_text) begin
      lane_nxt = q_item.last ? '0 : m_new;
    end else if (pop && clr) begin
      lane_nxt = '0;
    end else if (state_r == smps_pkg::MS_PASS && pass_end) begin
      lane_nxt[j_r] = ok_r && pass_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smps_pkg::MS_RUN;
      lane_r      <= '0;
      len_r       <= '0;
      done_r      <= 1'b0;
      pos_r       <= '0;
      hit_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      if (pop) begin
        hit_valid_r <= 1'b1;
        if (is_text) begin
          if (q_item.last) begin
            pos_r <= '0;
          end else if (pos_r != smps_pkg::POS_MAX) begin
            pos_r <= pos_r + 1'b1;
          end
        end else begin
          if (fits) begin
            len_r <= len_eff + 1'b1;
          end
          done_r <= q_item.last;
          if (clr) begin
            pos_r <= '0;
          end
        end
      end else if (hit_ready) begin
        hit_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_text && fits) begin
      pat_r[len_eff[smps_pkg::LANE_W-1:0]] <= q_item.chr;
    end
    if (pop && is_text) begin
      hist_r[0] <= q_item.chr;
      for (int i = 1; i < smps_pkg::PAT_MAX; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    if (pop) begin
      hit_r.clr      <= clr;
      hit_r.text     <= is_text;
      hit_r.last     <= is_text && q_item.last;
      hit_r.hit      <= hit_raw;
      hit_r.start    <= start;
      hit_r.prev_chr <= hist_r[len_m1];
    end
    if (pass_go) begin
      k_r  <= '0;
      j_r  <= len_r[smps_pkg::LANE_W-1:0];
      ok_r <= 1'b1;
    end else if (state_r == smps_pkg::MS_PASS && !pass_end) begin
      k_r  <= k_r + 1'b1;
      ok_r <= ok_r && pass_eq;
    end
  end

  assign hit_valid = hit_valid_r;
  assign hit_info  = hit_r;

  `SMPS_ASSERT_IMPL(a_pass_count, state_r == smps_pkg::MS_PASS, k_r <= j_r, "pass index past lane")
  `SMPS_ASSERT_IMPL(a_pass_lane, state_r == smps_pkg::MS_PASS, int'(len_r) == int'(j_r) + 1, "pass lane is not the newest pattern byte")

endmodule

// ===== rtl/core/smps_score.sv =====
// ----------------------------------------------------------------------------
// smps_score
// first-match tracking, position scoring and the result register
// ----------------------------------------------------------------------------
`include "substring_match_position_scorer_defines.svh"

module smps_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smps_pkg::cfg_t       cfg,
  input  logic                 hit_valid,
  output logic                 hit_ready,
  input  smps_pkg::hit_info_t  hit_info,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smps_pkg::out_item_t  out_data
);

  logic                 out_valid_r;
  smps_pkg::out_item_t  out_r;
  logic                 seen_r;
  logic [15:0]          score_r;

  logic                 out_free;
  logic                 take;
  logic                 emit;
  logic                 delim;
  logic                 new_hit;
  logic                 seen_now;
  logic [15:0]          sc;
  logic [15:0]          score_now;

  assign out_free  = !out_valid_r || out_ready;
  assign hit_ready = !(hit_info.text && hit_info.last) || out_free;
  assign take      = hit_valid && hit_ready;
  assign emit      = take && hit_info.text && hit_info.last;

  always_comb begin
    delim = 1'b0;
    for (int k = 0; k < smps_pkg::DELIM_SLOTS; k++) begin
      if (k < int'(cfg.delimiter_count) &&
          cfg.delimiter_chars[8*k +: 8] == hit_info.prev_chr) begin
        delim = 1'b1;
      end
    end
  end

  always_comb begin
    if (hit_info.start == '0) begin
      sc = cfg.max_weight;
    end else if (cfg.use_delimiter && delim) begin
      sc = (cfg.max_weight > 16'd1) ? cfg.max_weight - 16'd1 : '0;
    end else begin
      sc = (cfg.max_weight > hit_info.start) ? cfg.max_weight - hit_info.start - 16'd1 : '0;
    end
  end

  assign new_hit   = hit_info.hit && !seen_r;
  assign seen_now  = seen_r || new_hit;
  assign score_now = new_hit ? sc : score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      score_r     <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (hit_info.clr || emit) begin
          seen_r  <= 1'b0;
          score_r <= '0;
        end else if (hit_info.text) begin
          seen_r  <= seen_now;
          score_r <= score_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.score <= seen_now ? score_now : cfg.min_weight;
      out_r.found <= seen_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SMPS_ASSERT_IMPL(a_score_clear, !seen_r, score_r == '0, "score held without a match")

endmodule

// ===== rtl/core/substring_match_position_scorer.sv =====
// ----------------------------------------------------------------------------
// substring_match_position_scorer
// case-insensitive first-occurrence search with position-based scoring
// ----------------------------------------------------------------------------
// Pattern bytes (operation 0) load a pattern of up to 64 bytes; the byte
// marked last completes it, and the next pattern byte starts a new pattern
// and clears the text side. Text bytes (operation 1) stream in and one
// result (score, found) follows each text byte marked last. Both sides are
// compared after folding A-Z to lower case. Items are taken at one per
// cycle while the output side does not stall: a per-lane prefix match
// vector advances once per text byte. The exception is a pattern byte that
// extends the pattern after more bytes of the current text have arrived
// than the pattern held: the match engine then rebuilds that lane from the
// stored history, one byte a cycle, while the input queue keeps filling. A
// result passes the input register, the queue, the match stage register
// and the output register, with scoring done as the output register
// loads. The pattern store needs no clearing after reset.
// ----------------------------------------------------------------------------
module substring_match_position_scorer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  smps_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output smps_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [smps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  smps_pkg::cfg_t       cfg_r;
  logic                 fr_valid;
  logic                 fr_ready;
  smps_pkg::work_item_t fr_item;
  logic                 q_valid;
  logic                 q_ready;
  smps_pkg::work_item_t q_item;
  logic                 hit_valid;
  logic                 hit_ready;
  smps_pkg::hit_info_t  hit_info;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= smps_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (smps_pkg::cfg_idx_t'(cfg_index))
        smps_pkg::CFG_MIN_WEIGHT:  cfg_r.min_weight      <= cfg_wdata[15:0];
        smps_pkg::CFG_MAX_WEIGHT:  cfg_r.max_weight      <= cfg_wdata[15:0];
        smps_pkg::CFG_USE_DELIM:   cfg_r.use_delimiter   <= cfg_wdata[0];
        smps_pkg::CFG_DELIM_CHARS: cfg_r.delimiter_chars <= cfg_wdata[23:0];
        smps_pkg::CFG_DELIM_COUNT: cfg_r.delimiter_count <= cfg_wdata[1:0];
        default:                   cfg_r                 <= cfg_r;
      endcase
    end
  end

  smps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item)
  );

  smps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  smps_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit_info  (hit_info)
  );

  smps_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit_info  (hit_info),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/substring_match_position_scorer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_match_position_scorer_tb
// Drives pattern and text bytes through the valid/ready input channel and
// checks every score against a behavioral model of the case-insensitive
// first-occurrence search. The sender works in bursts with random gaps
// (none in the overflow phase) and the receiver stalls on its own
// pattern. Register settings change between phases. The phases cover
// directed cases, pattern overflow, a delimiter ahead of a late match,
// and random traffic that is mostly well-formed pattern/text sequences.
// ----------------------------------------------------------------------------
module substring_match_position_scorer_tb;

  class match_scoreboard;
    logic [15:0]         min_w;
    logic [15:0]         max_w;
    logic                use_delim;
    logic [23:0]         delim_chars;
    logic [1:0]          delim_cnt;
    logic [7:0]          pat [smps_pkg::PAT_MAX];
    int unsigned         pat_len;
    bit                  pat_done;
    logic [7:0]          window [smps_pkg::PAT_MAX + 1];
    int unsigned         text_pos;
    bit                  seen;
    int unsigned         score_hold;
    smps_pkg::out_item_t score_q [$];
    int unsigned         errors;

    function new();
      min_w       = smps_pkg::CFG_RESET.min_weight;
      max_w       = smps_pkg::CFG_RESET.max_weight;
      use_delim   = smps_pkg::CFG_RESET.use_delimiter;
      delim_chars = smps_pkg::CFG_RESET.delimiter_chars;
      delim_cnt   = smps_pkg::CFG_RESET.delimiter_count;
      pat_len     = 0;
      pat_done    = 0;
      errors      = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = 8'h00;
      text_pos   = 0;
      seen       = 0;
      score_hold = 0;
    endfunction

    function void write_reg(smps_pkg::cfg_idx_t idx,
                            logic [smps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        smps_pkg::CFG_MIN_WEIGHT:  min_w = value[15:0];
        smps_pkg::CFG_MAX_WEIGHT:  max_w = value[15:0];
        smps_pkg::CFG_USE_DELIM:   use_delim = value[0];
        smps_pkg::CFG_DELIM_CHARS: delim_chars = value[23:0];
        smps_pkg::CFG_DELIM_COUNT: delim_cnt = value[1:0];
        default: ;
      endcase
    endfunction

    function void absorb_item(smps_pkg::in_item_t it);
      logic [7:0]          ch;
      int unsigned         idx;
      int unsigned         start;
      int                  i;
      bit                  hit;
      bit                  is_delim;
      smps_pkg::out_item_t res;
      ch = it.char_code;
      if (ch >= smps_pkg::ASCII_UPPER_A && ch <= smps_pkg::ASCII_UPPER_Z)
        ch = ch + smps_pkg::ASCII_CASE_GAP;
      if (it.operation == smps_pkg::OP_PATTERN) begin
        if (pat_done) begin
          pat_len  = 0;
          pat_done = 0;
          clear_text();
        end
        if (pat_len < smps_pkg::PAT_MAX) begin
          pat[pat_len] = ch;
          pat_len++;
        end
        if (it.last) pat_done = 1;
        return;
      end
      for (i = smps_pkg::PAT_MAX; i > 0; i--) window[i] = window[i-1];
      window[0] = ch;
      idx = text_pos;
      if (text_pos < 32'hFFFF) text_pos++;
      if (!seen && pat_len > 0 && idx + 1 >= pat_len) begin
        hit = 1;
        for (i = 0; i < pat_len; i++) begin
          if (window[i] != pat[pat_len - 1 - i]) hit = 0;
        end
        if (hit) begin
          start = (idx >= 32'hFFFF) ? 32'hFFFF : idx + 1 - pat_len;
          is_delim = 0;
          for (i = 0; i < delim_cnt; i++) begin
            if (delim_chars[8*i +: 8] == window[pat_len]) is_delim = 1;
          end
          if (start == 0) begin
            score_hold = max_w;
          end else if (use_delim && is_delim) begin
            score_hold = (max_w > 1) ? max_w - 1 : 0;
          end else begin
            score_hold = (max_w > start + 1) ? max_w - (start + 1) : 0;
          end
          seen = 1;
        end
      end
      if (it.last) begin
        res.score = seen ? score_hold[15:0] : min_w;
        res.found = seen;
        score_q.insert(score_q.size(), res);
        clear_text();
      end
    endfunction

    function void check_score(smps_pkg::out_item_t got);
      smps_pkg::out_item_t want;
      if (score_q.size() == 0) begin
        $display("%0t: unexpected result, score %0d found %0b", $time, got.score, got.found);
        errors++;
        return;
      end
      want = score_q.pop_front();
      if (got.score !== want.score) begin
        $display("%0t: score mismatch, expected %0d actual %0d", $time, want.score, got.score);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_HOLD} ready_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  smps_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  smps_pkg::out_item_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [smps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [smps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  match_scoreboard    sb = new();
  smps_pkg::in_item_t send_q [$];
  int unsigned        queued_total = 0;
  int unsigned        accepted_total = 0;
  int unsigned        burst_left = 1;
  int unsigned        gap_left = 0;
  bit                 steady_send = 0;
  ready_mode_t        ready_mode = RDY_ALWAYS;
  int unsigned        ready_left = 0;

  substring_match_position_scorer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // input transfer and burst/gap sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sb.absorb_item(in_data);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && !steady_send) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_data  <= send_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result transfer and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_score(out_data);
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 80);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= (ready_left < 10);
    endcase
  end

  function automatic void queue_item(smps_pkg::op_t op, logic [7:0] code, bit mark_last);
    smps_pkg::in_item_t it;
    it.operation = op;
    it.char_code = code;
    it.last      = mark_last;
    send_q.insert(send_q.size(), it);
    queued_total++;
  endfunction

  function automatic void queue_bytes(smps_pkg::op_t op, string s, bit mark_last);
    int i;
    for (i = 0; i < s.len(); i++) queue_item(op, s[i], mark_last && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return sb.delim_chars[8*$urandom_range(0, 2) +: 8];
      2: return "-";
      3: return "_";
      4: return "+";
      5: return "b";
      6: return "c";
      default: return "a";
    endcase
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - smps_pkg::ASCII_CASE_GAP;
    return c;
  endfunction

  task automatic write_reg(smps_pkg::cfg_idx_t idx, logic [smps_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] min_w, logic [15:0] max_w, logic use_delim,
                         logic [23:0] chars, logic [1:0] cnt);
    write_reg(smps_pkg::CFG_MIN_WEIGHT, {8'h00, min_w});
    write_reg(smps_pkg::CFG_MAX_WEIGHT, {8'h00, max_w});
    write_reg(smps_pkg::CFG_USE_DELIM, {23'h000000, use_delim});
    write_reg(smps_pkg::CFG_DELIM_CHARS, chars);
    write_reg(smps_pkg::CFG_DELIM_COUNT, {22'h000000, cnt});
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || sb.score_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned n_items);
    logic [7:0]  pat_bytes [$];
    logic [7:0]  text_bytes [$];
    int unsigned base;
    int unsigned plen;
    int unsigned k;
    base = queued_total;
    while (queued_total - base < n_items) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8))
          queue_item(smps_pkg::op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 2) == 0);
      end else begin
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 70) : $urandom_range(1, 5);
        pat_bytes.delete();
        repeat (plen) pat_bytes.insert(pat_bytes.size(), pick_char());
        for (k = 0; k < plen; k++)
          queue_item(smps_pkg::OP_PATTERN, vary_case(pat_bytes[k]), k == plen - 1);
        repeat ($urandom_range(1, 4)) begin
          text_bytes.delete();
          repeat ($urandom_range(0, 8)) text_bytes.insert(text_bytes.size(), pick_char());
          if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 1)
              text_bytes.insert(text_bytes.size(), sb.delim_chars[8*$urandom_range(0, 2) +: 8]);
            for (k = 0; k < plen && k < smps_pkg::PAT_MAX; k++)
              text_bytes.insert(text_bytes.size(), vary_case(pat_bytes[k]));
            // near miss
            if ($urandom_range(0, 4) == 0) void'(text_bytes.pop_back());
            repeat ($urandom_range(0, 4)) text_bytes.insert(text_bytes.size(), pick_char());
          end
          if (text_bytes.size() == 0) text_bytes.insert(0, pick_char());
          for (k = 0; k < text_bytes.size(); k++)
            queue_item(smps_pkg::OP_TEXT, text_bytes[k], k == text_bytes.size() - 1);
        end
      end
    end
  endtask

  initial begin
    logic [7:0] long_pat [$];
    int         k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases at reset settings
    queue_bytes(smps_pkg::OP_TEXT, "a", 1'b1);
    queue_bytes(smps_pkg::OP_PATTERN, "Ab", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "aB", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "x-ab", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "zyAb", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "q", 1'b1);
    queue_item(smps_pkg::OP_PATTERN, 8'hFF, 1'b1);
    queue_item(smps_pkg::OP_TEXT, 8'h00, 1'b0);
    queue_item(smps_pkg::OP_TEXT, 8'hFF, 1'b1);
    queue_bytes(smps_pkg::OP_PATTERN, "c", 1'b0);
    queue_bytes(smps_pkg::OP_TEXT, "x", 1'b0);
    queue_bytes(smps_pkg::OP_PATTERN, "D", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "cd", 1'b1);
    queue_bytes(smps_pkg::OP_TEXT, "+cdcd", 1'b1);
    wait_idle();

    // pattern overflow, then a delimiter ahead of a late match
    set_all(16'hFFFF, 16'hFFFF, 1'b1, smps_pkg::CFG_RESET.delimiter_chars, 2'd3);
    steady_send = 1;
    repeat (smps_pkg::PAT_MAX + 2) long_pat.insert(long_pat.size(), pick_char());
    for (k = 0; k < smps_pkg::PAT_MAX + 2; k++)
      queue_item(smps_pkg::OP_PATTERN, long_pat[k], k == smps_pkg::PAT_MAX + 1);
    queue_bytes(smps_pkg::OP_TEXT, ".", 1'b0);
    for (k = 0; k < smps_pkg::PAT_MAX; k++)
      queue_item(smps_pkg::OP_TEXT, vary_case(long_pat[k]), k == smps_pkg::PAT_MAX - 1);
    queue_bytes(smps_pkg::OP_PATTERN, "AB", 1'b1);
    repeat (40) queue_item(smps_pkg::OP_TEXT, "x", 1'b0);
    queue_bytes(smps_pkg::OP_TEXT, "_ab", 1'b1);
    wait_idle();
    steady_send = 0;

    set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40)), 1'b1,
            {8'h2E, 8'h2B, 8'h5F}, 2'($urandom_range(1, 3)));
    queue_random(190);
    wait_idle();

    set_all(16'hFFFF, 16'h0000, 1'b0, 24'hFFFFFF, 2'd0);
    queue_random(180);
    wait_idle();

    set_all(16'h0000, 16'hFFFF, 1'b1, 24'h000000, 2'd3);
    queue_random(190);
    wait_idle();

    set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)),
            2'($urandom_range(0, 3)));
    queue_random(190);
    wait_idle();

    if (sb.errors == 0 && sb.score_q.size() == 0) begin
      $display("[substring_match_position_scorer] OK");
    end else begin
      $display("[substring_match_position_scorer] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[substring_match_position_scorer] ERROR");
    $finish;
  end

endmodule
